[design/grid_stencil_matrix_entry_generator_top_defines.svh]
`ifndef GRID_STENCIL_MATRIX_ENTRY_GENERATOR_TOP_DEFINES_SVH
`define GRID_STENCIL_MATRIX_ENTRY_GENERATOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define GSME_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define GSME_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/gsme_pkg.sv]
package gsme_pkg;

  // Limits applied to the configuration registers
  localparam int MAX_GRID   = 256;
  localparam int MAX_FIELDS = 4;
  localparam int MAX_DIMS   = 4;

  // Field widths
  localparam int COORD_W    = 8;
  localparam int FLD_W      = 2;
  localparam int COMP_W     = 2;
  localparam int IDX_W      = 20;
  localparam int COEF_W     = 3;
  localparam int KIND_W     = 2;
  localparam int NSZ_W      = 9;
  localparam int CNT_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OPERATOR_KIND = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_COUNT   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_VECTOR_DIMS   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_BOUNDARY_MODE = CFG_IDX_W'(4);

  // Register reset values
  localparam int RST_GRID   = 64;
  localparam int RST_FIELDS = 1;
  localparam int RST_DIMS   = 2;
  localparam int MIN_GRID   = 3;

  // Operator codes; the fourth code selects nothing
  localparam logic [KIND_W-1:0] KIND_LAPLACE = KIND_W'(0);
  localparam logic [KIND_W-1:0] KIND_DIV     = KIND_W'(1);
  localparam logic [KIND_W-1:0] KIND_GRAD    = KIND_W'(2);

  // Stencil slots in emission order
  localparam int NSLOT      = 5;
  localparam int SLOT_IDX_W = $clog2(NSLOT);
  localparam logic [SLOT_IDX_W-1:0] SLOT_CENTRE = SLOT_IDX_W'(0);
  localparam logic [SLOT_IDX_W-1:0] SLOT_XM     = SLOT_IDX_W'(1);
  localparam logic [SLOT_IDX_W-1:0] SLOT_XP     = SLOT_IDX_W'(2);
  localparam logic [SLOT_IDX_W-1:0] SLOT_YM     = SLOT_IDX_W'(3);
  localparam logic [SLOT_IDX_W-1:0] SLOT_YP     = SLOT_IDX_W'(4);

  // Stencil weights
  localparam logic signed [COEF_W-1:0] COEF_CENTRE = -3'sd4;
  localparam logic signed [COEF_W-1:0] COEF_MINUS  = -3'sd1;
  localparam logic signed [COEF_W-1:0] COEF_PLUS   = 3'sd1;

  // Index arithmetic widths (full precision, truncated at the output)
  localparam int CELL_W = COORD_W + NSZ_W + 1;
  localparam int CF_W   = CELL_W + CNT_W + 1;
  localparam int CALC_W = CF_W + CNT_W + 1;

  // Item queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [COORD_W-1:0] coord_t;

  // Saturated configuration as seen by the datapath
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [NSZ_W-1:0]  grid_n;
    logic [CNT_W-1:0]  fields;
    logic [CNT_W-1:0]  dims;
    logic              wrap;
  } cfg_t;

  // Classified element waiting for expansion
  typedef struct packed {
    coord_t             cell_y;
    coord_t             cell_x;
    coord_t             xm;
    coord_t             xp;
    coord_t             ym;
    coord_t             yp;
    logic [FLD_W-1:0]   field_index;
    logic [COMP_W-1:0]  component;
    logic [NSLOT-1:0]   mask;
  } item_t;

endpackage

[design/gsme_if.sv]
// Input channel: one grid element per transfer
interface gsme_in_if;
  import gsme_pkg::*;
  logic              valid;
  logic              ready;
  coord_t            cell_y;
  coord_t            cell_x;
  logic [FLD_W-1:0]  field_index;
  logic [COMP_W-1:0] component;

  modport source (output valid, cell_y, cell_x, field_index, component, input ready);
  modport sink   (input valid, cell_y, cell_x, field_index, component, output ready);
endinterface

// Result channel: one matrix entry per transfer
interface gsme_out_if;
  import gsme_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         row_index;
  logic [IDX_W-1:0]         col_index;
  logic signed [COEF_W-1:0] coefficient;
  logic                     last;

  modport source (output valid, row_index, col_index, coefficient, last, input ready);
  modport sink   (input valid, row_index, col_index, coefficient, last, output ready);
endinterface

// Configuration write channel
interface gsme_cfg_if;
  import gsme_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[design/grid_stencil_matrix_entry_generator_top.sv]
// Finite-difference matrix entry generator. Each input transfer names one grid
// element (cell_y, cell_x, field_index, component); the block emits that
// element's sparse-matrix entries (row_index, col_index, coefficient) for the
// five-point Laplacian, central divergence or central gradient, with last set
// on the final entry. Coefficients are unscaled and coinciding entries are not
// summed. Elements outside the configured grid, or an unused operator code,
// produce no entries and are consumed by the front without being queued. The
// front classifies an element and parks it in a four-deep queue; the back
// issues one entry per cycle, unless the output stalls or the queue is empty,
// into a three-stage index pipeline (cell, field, component) that ends in the
// output register. A Laplacian element yields 3 to 5 entries, a divergence or
// gradient element 1 or 2, depending on how many neighbours survive the
// boundary. The user must write configuration through cfg_ch only while no
// element is in flight; the block itself does not enforce this.
module grid_stencil_matrix_entry_generator_top (
  input  logic       clk,
  input  logic       rst_n,
  gsme_cfg_if.sink   cfg_ch,
  gsme_in_if.sink    in_ch,
  gsme_out_if.source out_ch
);
  import gsme_pkg::*;

  cfg_t  cfg;
  logic  push, pop, q_full, q_empty;
  item_t push_item, q_head;

  gsme_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  gsme_front u_front (
    .cfg       (cfg),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  gsme_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  gsme_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (pop),
    .out_ch  (out_ch)
  );

endmodule

[design/gsme_cfg_regs.sv]
module gsme_cfg_regs (
  input  logic            clk,
  input  logic            rst_n,
  gsme_cfg_if.sink        cfg_ch,
  output gsme_pkg::cfg_t  cfg
);
  import gsme_pkg::*;

  cfg_t                 cfg_r;
  cfg_t                 cfg_nxt;
  logic [NSZ_W-1:0]     grid_w;
  logic [CNT_W-1:0]     fields_w;
  logic [CNT_W-1:0]     dims_w;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  // Saturate on write so the datapath always sees legal sizes
  always_comb begin
    grid_w   = cfg_ch.data[NSZ_W-1:0];
    fields_w = cfg_ch.data[CNT_W-1:0];
    dims_w   = cfg_ch.data[CNT_W-1:0];
    if (32'(grid_w) < MIN_GRID)        grid_w   = NSZ_W'(MIN_GRID);
    else if (32'(grid_w) > MAX_GRID)   grid_w   = NSZ_W'(MAX_GRID);
    if (fields_w == '0)                fields_w = CNT_W'(1);
    else if (32'(fields_w) > MAX_FIELDS) fields_w = CNT_W'(MAX_FIELDS);
    if (dims_w == '0)                  dims_w   = CNT_W'(1);
    else if (32'(dims_w) > MAX_DIMS)   dims_w   = CNT_W'(MAX_DIMS);

    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_OPERATOR_KIND: cfg_nxt.kind   = cfg_ch.data[KIND_W-1:0];
        REG_GRID_SIZE:     cfg_nxt.grid_n = grid_w;
        REG_FIELD_COUNT:   cfg_nxt.fields = fields_w;
        REG_VECTOR_DIMS:   cfg_nxt.dims   = dims_w;
        REG_BOUNDARY_MODE: cfg_nxt.wrap   = cfg_ch.data[0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kind   <= KIND_LAPLACE;
      cfg_r.grid_n <= NSZ_W'(RST_GRID);
      cfg_r.fields <= CNT_W'(RST_FIELDS);
      cfg_r.dims   <= CNT_W'(RST_DIMS);
      cfg_r.wrap   <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[design/gsme_front.sv]
module gsme_front (
  input  gsme_pkg::cfg_t  cfg,
  gsme_in_if.sink         in_ch,
  input  logic            q_full,
  output logic            push,
  output gsme_pkg::item_t push_item
);
  import gsme_pkg::*;

  // {kept, coordinate} of the lower neighbour
  function automatic logic [COORD_W:0] step_down(input coord_t c,
                                                 input logic [NSZ_W-1:0] n,
                                                 input logic wrap);
    logic [COORD_W:0] res;
    if (c == '0) res = {wrap, COORD_W'(n - NSZ_W'(2))};
    else         res = {1'b1, c - COORD_W'(1)};
    return res;
  endfunction

  // {kept, coordinate} of the upper neighbour
  function automatic logic [COORD_W:0] step_up(input coord_t c,
                                               input logic [NSZ_W-1:0] n,
                                               input logic wrap);
    logic [COORD_W:0] res;
    if ({1'b0, c} == n - NSZ_W'(1)) res = {wrap, COORD_W'(1)};
    else                            res = {1'b1, c + COORD_W'(1)};
    return res;
  endfunction

  logic [COORD_W:0] xm_w, xp_w, ym_w, yp_w;
  logic             in_grid;
  logic             item_ok;
  logic [NSLOT-1:0] mask_w;

  assign in_ch.ready = !q_full;

  // Neighbour coordinates and boundary handling
  assign xm_w = step_down(in_ch.cell_x, cfg.grid_n, cfg.wrap);
  assign xp_w = step_up(in_ch.cell_x, cfg.grid_n, cfg.wrap);
  assign ym_w = step_down(in_ch.cell_y, cfg.grid_n, cfg.wrap);
  assign yp_w = step_up(in_ch.cell_y, cfg.grid_n, cfg.wrap);

  assign in_grid = ({1'b0, in_ch.cell_y} < cfg.grid_n) &&
                   ({1'b0, in_ch.cell_x} < cfg.grid_n) &&
                   ({1'b0, in_ch.field_index} < cfg.fields);

  // Classify: which stencil slots this element emits
  always_comb begin
    item_ok = 1'b0;
    mask_w  = '0;
    unique case (cfg.kind) inside
      KIND_LAPLACE: begin
        item_ok = in_grid && ({1'b0, in_ch.component} < cfg.dims);
        mask_w  = {yp_w[COORD_W], ym_w[COORD_W], xp_w[COORD_W], xm_w[COORD_W], 1'b1};
      end
      KIND_DIV, KIND_GRAD: begin
        item_ok = in_grid && (in_ch.component < COMP_W'(2));
        if (in_ch.component[0]) mask_w = {yp_w[COORD_W], ym_w[COORD_W], 3'b000};
        else                    mask_w = {2'b00, xp_w[COORD_W], xm_w[COORD_W], 1'b0};
      end
      default: begin
        item_ok = 1'b0;
        mask_w  = '0;
      end
    endcase
  end

  // Elements that emit nothing are consumed here and never queued
  assign push = in_ch.valid && in_ch.ready && item_ok && (mask_w != '0);

  assign push_item.cell_y      = in_ch.cell_y;
  assign push_item.cell_x      = in_ch.cell_x;
  assign push_item.xm          = xm_w[COORD_W-1:0];
  assign push_item.xp          = xp_w[COORD_W-1:0];
  assign push_item.ym          = ym_w[COORD_W-1:0];
  assign push_item.yp          = yp_w[COORD_W-1:0];
  assign push_item.field_index = in_ch.field_index;
  assign push_item.component   = in_ch.component;
  assign push_item.mask        = mask_w;

endmodule

[design/gsme_queue.sv]
module gsme_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  gsme_pkg::item_t push_item,
  input  logic            pop,
  output logic            full,
  output logic            empty,
  output gsme_pkg::item_t head
);
  import gsme_pkg::*;

  item_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop)      cnt_nxt = cnt_r + QCNT_W'(1);
    else if (pop && !push) cnt_nxt = cnt_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

endmodule

[design/gsme_back.sv]
module gsme_back (
  input  logic            clk,
  input  logic            rst_n,
  input  gsme_pkg::cfg_t  cfg,
  input  logic            q_empty,
  input  gsme_pkg::item_t q_head,
  output logic            q_pop,
  gsme_out_if.source      out_ch
);
  import gsme_pkg::*;

  // Slot walker
  logic [NSLOT-1:0]      done_r, done_nxt;
  logic [NSLOT-1:0]      remain;
  logic [NSLOT-1:0]      pick;
  logic [SLOT_IDX_W-1:0] pick_idx;
  logic                  adv, issue, is_last;
  coord_t                col_y, col_x;
  logic signed [COEF_W-1:0] coef_w;

  // Stage 1: cell numbers
  logic                     s1_vld_r;
  logic [CELL_W-1:0]        s1_row_cell_r, s1_col_cell_r;
  logic [FLD_W-1:0]         s1_field_r;
  logic [COMP_W-1:0]        s1_comp_r;
  logic signed [COEF_W-1:0] s1_coef_r;
  logic                     s1_last_r;

  // Stage 2: cell and field
  logic                     s2_vld_r;
  logic [CF_W-1:0]          s2_row_cf_r, s2_col_cf_r;
  logic [COMP_W-1:0]        s2_comp_r;
  logic signed [COEF_W-1:0] s2_coef_r;
  logic                     s2_last_r;

  // Stage 3: output register
  logic                     out_vld_r;
  logic [IDX_W-1:0]         out_row_r, out_col_r;
  logic signed [COEF_W-1:0] out_coef_r;
  logic                     out_last_r;

  logic [CNT_W-1:0]         m_row, m_col;
  logic [COMP_W-1:0]        dd_row, dd_col;
  logic [CALC_W-1:0]        row_full, col_full;
  logic                     found;

  // Whole pipeline moves when the output register is free or being drained
  assign adv   = !out_vld_r || out_ch.ready;
  assign issue = adv && !q_empty;

  // Next slot of the head element, lowest first
  assign remain = q_head.mask & ~done_r;

  always_comb begin
    pick     = '0;
    pick_idx = '0;
    found    = 1'b0;
    for (int k = 0; k < NSLOT; k++) begin
      if (remain[k] && !found) begin
        pick[k]  = 1'b1;
        pick_idx = SLOT_IDX_W'(k);
        found    = 1'b1;
      end
    end
  end

  assign is_last = ((remain & ~pick) == '0);
  assign q_pop   = issue && is_last;

  always_comb begin
    done_nxt = done_r;
    if (issue) done_nxt = is_last ? '0 : (done_r | pick);
  end

  // Column cell and weight of the chosen slot
  always_comb begin
    col_y = q_head.cell_y;
    col_x = q_head.cell_x;
    unique case (pick_idx)
      SLOT_CENTRE: ;
      SLOT_XM:     col_x = q_head.xm;
      SLOT_XP:     col_x = q_head.xp;
      SLOT_YM:     col_y = q_head.ym;
      SLOT_YP:     col_y = q_head.yp;
      default:     ;
    endcase
    if (pick_idx == SLOT_CENTRE)                       coef_w = COEF_CENTRE;
    else if (cfg.kind == KIND_LAPLACE)                 coef_w = COEF_PLUS;
    else if (pick_idx == SLOT_XM || pick_idx == SLOT_YM) coef_w = COEF_MINUS;
    else                                               coef_w = COEF_PLUS;
  end

  // Row and column layouts of the selected operator
  always_comb begin
    m_row  = cfg.dims;
    m_col  = cfg.dims;
    dd_row = s2_comp_r;
    dd_col = s2_comp_r;
    if (cfg.kind == KIND_DIV) begin
      m_row  = CNT_W'(1);
      dd_row = '0;
      m_col  = CNT_W'(2);
    end else if (cfg.kind == KIND_GRAD) begin
      m_row  = CNT_W'(2);
      m_col  = CNT_W'(1);
      dd_col = '0;
    end
  end

  assign row_full = CALC_W'(s2_row_cf_r * m_row) + CALC_W'(dd_row);
  assign col_full = CALC_W'(s2_col_cf_r * m_col) + CALC_W'(dd_col);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r    <= '0;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
      if (adv) begin
        s1_vld_r  <= issue;
        s2_vld_r  <= s1_vld_r;
        out_vld_r <= s2_vld_r;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_row_cell_r <= CELL_W'({1'b0, q_head.cell_y} * cfg.grid_n) + CELL_W'(q_head.cell_x);
      s1_col_cell_r <= CELL_W'({1'b0, col_y} * cfg.grid_n) + CELL_W'(col_x);
      s1_field_r    <= q_head.field_index;
      s1_comp_r     <= q_head.component;
      s1_coef_r     <= coef_w;
      s1_last_r     <= is_last;

      s2_row_cf_r   <= CF_W'(s1_row_cell_r * cfg.fields) + CF_W'(s1_field_r);
      s2_col_cf_r   <= CF_W'(s1_col_cell_r * cfg.fields) + CF_W'(s1_field_r);
      s2_comp_r     <= s1_comp_r;
      s2_coef_r     <= s1_coef_r;
      s2_last_r     <= s1_last_r;

      out_row_r     <= row_full[IDX_W-1:0];
      out_col_r     <= col_full[IDX_W-1:0];
      out_coef_r    <= s2_coef_r;
      out_last_r    <= s2_last_r;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.row_index   = out_row_r;
  assign out_ch.col_index   = out_col_r;
  assign out_ch.coefficient = out_coef_r;
  assign out_ch.last        = out_last_r;

endmodule

[design/gsme_checker.sv]
`include "grid_stencil_matrix_entry_generator_top_defines.svh"

module gsme_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [gsme_pkg::IDX_W-1:0]         row_index,
  input logic [gsme_pkg::IDX_W-1:0]         col_index,
  input logic signed [gsme_pkg::COEF_W-1:0] coefficient,
  input logic                               last
);
  import gsme_pkg::*;

  // A stalled entry holds
  `GSME_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(row_index) && $stable(col_index) && $stable(coefficient) && $stable(last), "result changed while stalled")

  // The centre weight sits on the diagonal
  `GSME_ASSERT_NOW(a_centre_diag, out_valid && (coefficient == COEF_CENTRE), row_index == col_index, "centre entry off the diagonal")

  // A Laplacian element always has a neighbour after its centre entry
  `GSME_ASSERT_NOW(a_centre_not_last, out_valid && (coefficient == COEF_CENTRE), !last, "centre entry marked last")

  // Entries of one element share a row
  `GSME_ASSERT_NEXT(a_item_row, out_valid && out_ready && !last, !out_valid || (row_index == $past(row_index)), "row changed inside one element")

endmodule

bind grid_stencil_matrix_entry_generator_top gsme_checker u_gsme_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .row_index   (out_ch.row_index),
  .col_index   (out_ch.col_index),
  .coefficient (out_ch.coefficient),
  .last        (out_ch.last)
);

[tb/sv/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gsme_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int DRAIN_CYCLES  = 24;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 32;
  localparam int NONE_ITEMS    = 8;

  // operator code with no stencil behind it; register slot with no register
  localparam logic [KIND_W-1:0]    KIND_NONE  = KIND_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(5);

  typedef struct packed {
    coord_t            cell_y;
    coord_t            cell_x;
    logic [FLD_W-1:0]  field_index;
    logic [COMP_W-1:0] component;
  } elem_t;

  typedef struct {
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic signed [COEF_W-1:0] coefficient;
    logic                     last;
  } entry_t;

  logic clk;
  logic rst_n;

  gsme_cfg_if cfg_bus();
  gsme_in_if  elem_bus();
  gsme_out_if entry_bus();

  grid_stencil_matrix_entry_generator_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_bus),
    .in_ch  (elem_bus),
    .out_ch (entry_bus)
  );

  // shadow of the register file, raw as written
  logic [KIND_W-1:0] op_kind   = KIND_LAPLACE;
  logic [NSZ_W-1:0]  grid_raw  = NSZ_W'(RST_GRID);
  logic [CNT_W-1:0]  field_raw = CNT_W'(RST_FIELDS);
  logic [CNT_W-1:0]  dims_raw  = CNT_W'(RST_DIMS);
  logic              wrap_raw  = 1'b0;

  elem_t  queued_elems[$];
  entry_t awaited_entries[$];
  elem_t  driven_elem;
  bit     elem_in_flight;
  bit     sender_quiet;
  bit     sink_quiet;
  int     send_gap;
  int     stall_left;
  int     error_count;
  int     elems_sent;
  int     silent_elems;
  int     entries_checked;
  int     configs_applied;
  int     cycle_count;

  always #5 clk = ~clk;

  // effective sizes after saturation
  function automatic int grid_n();
    if (grid_raw < MIN_GRID) return MIN_GRID;
    if (grid_raw > MAX_GRID) return MAX_GRID;
    return int'(grid_raw);
  endfunction

  function automatic int fields_n();
    if (field_raw < 1) return 1;
    if (field_raw > MAX_FIELDS) return MAX_FIELDS;
    return int'(field_raw);
  endfunction

  function automatic int dims_n();
    if (dims_raw < 1) return 1;
    if (dims_raw > MAX_DIMS) return MAX_DIMS;
    return int'(dims_raw);
  endfunction

  // neighbour one step away; wraps to n-2 / 1 or is dropped at the edge
  function automatic bit adjacent_coord(input int c, input int off, input int n,
                                        input bit wrap, output int res);
    res = c;
    if (off < 0) begin
      if (c == 0) begin
        if (!wrap) return 1'b0;
        res = n - 2;
        return 1'b1;
      end
      res = c - 1;
      return 1'b1;
    end
    if (c + 1 >= n) begin
      if (!wrap) return 1'b0;
      res = 1;
      return 1'b1;
    end
    res = c + 1;
    return 1'b1;
  endfunction

  function automatic void add_entry(input int row, input int col,
                                    input logic signed [COEF_W-1:0] coef);
    entry_t e;
    e.row_index   = IDX_W'(row);
    e.col_index   = IDX_W'(col);
    e.coefficient = coef;
    e.last        = 1'b0;
    awaited_entries = {awaited_entries, e};
  endfunction

  // matrix entries that one grid element yields under the current registers
  function automatic void predict_entries(input elem_t e);
    int n, nf, nv, j, i, f, d, nb, cj, ci, row, col, cnt;
    bit is_div, ok;
    n   = grid_n();
    nf  = fields_n();
    nv  = dims_n();
    j   = int'(e.cell_y);
    i   = int'(e.cell_x);
    f   = int'(e.field_index);
    d   = int'(e.component);
    cnt = 0;
    if (op_kind == KIND_NONE || j >= n || i >= n || f >= nf) begin
      silent_elems++;
      return;
    end
    if (op_kind == KIND_LAPLACE) begin
      if (d >= nv) begin
        silent_elems++;
        return;
      end
      row = ((j * n + i) * nf + f) * nv + d;
      add_entry(row, row, COEF_CENTRE);
      cnt++;
      for (int off = -1; off < 2; off += 2) begin
        if (adjacent_coord(i, off, n, wrap_raw, nb)) begin
          add_entry(row, ((j * n + nb) * nf + f) * nv + d, COEF_PLUS);
          cnt++;
        end
      end
      for (int off = -1; off < 2; off += 2) begin
        if (adjacent_coord(j, off, n, wrap_raw, nb)) begin
          add_entry(row, ((nb * n + i) * nf + f) * nv + d, COEF_PLUS);
          cnt++;
        end
      end
    end else begin
      if (d >= 2) begin
        silent_elems++;
        return;
      end
      is_div = (op_kind == KIND_DIV);
      row = is_div ? (j * n + i) * nf + f : ((j * n + i) * nf + f) * 2 + d;
      for (int off = -1; off < 2; off += 2) begin
        cj = j;
        ci = i;
        if (d == 0) ok = adjacent_coord(i, off, n, wrap_raw, ci);
        else        ok = adjacent_coord(j, off, n, wrap_raw, cj);
        if (ok) begin
          col = is_div ? ((cj * n + ci) * nf + f) * 2 + d : (cj * n + ci) * nf + f;
          add_entry(row, col, (off < 0) ? COEF_MINUS : COEF_PLUS);
          cnt++;
        end
      end
    end
    if (cnt == 0) silent_elems++;
    else awaited_entries[awaited_entries.size() - 1].last = 1'b1;
  endfunction

  // mostly back-to-back, some short gaps, the odd long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // element driver
  always @(posedge clk) begin
    if (!rst_n) begin
      elem_bus.valid <= 1'b0;
      send_gap       = 0;
      elem_in_flight = 1'b0;
    end else begin
      if (elem_bus.valid && elem_bus.ready) begin
        predict_entries(driven_elem);
        elems_sent++;
        elem_in_flight = 1'b0;
      end
      if (!elem_in_flight) begin
        if (send_gap > 0) begin
          send_gap--;
          elem_bus.valid <= 1'b0;
        end else if (queued_elems.size() != 0) begin
          driven_elem = queued_elems.pop_front();
          elem_bus.cell_y      <= driven_elem.cell_y;
          elem_bus.cell_x      <= driven_elem.cell_x;
          elem_bus.field_index <= driven_elem.field_index;
          elem_bus.component   <= driven_elem.component;
          elem_bus.valid       <= 1'b1;
          elem_in_flight = 1'b1;
          send_gap       = sender_quiet ? 0 : pick_gap();
        end else begin
          elem_bus.valid <= 1'b0;
        end
      end
    end
  end

  // entry monitor and checker
  always @(posedge clk) begin
    entry_t exp_e;
    int r;
    if (!rst_n) begin
      entry_bus.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (entry_bus.valid && entry_bus.ready) begin
        if (awaited_entries.size() == 0) begin
          $error("unexpected matrix entry: row_index %0d col_index %0d",
                 entry_bus.row_index, entry_bus.col_index);
          error_count++;
        end else begin
          exp_e = awaited_entries.pop_front();
          entries_checked++;
          if (entry_bus.row_index !== exp_e.row_index) begin
            $error("row_index mismatch: expected %0d, got %0d",
                   exp_e.row_index, entry_bus.row_index);
            error_count++;
          end
          if (entry_bus.col_index !== exp_e.col_index) begin
            $error("col_index mismatch: expected %0d, got %0d",
                   exp_e.col_index, entry_bus.col_index);
            error_count++;
          end
          if (entry_bus.coefficient !== exp_e.coefficient) begin
            $error("coefficient mismatch: expected %0d, got %0d",
                   exp_e.coefficient, entry_bus.coefficient);
            error_count++;
          end
          if (entry_bus.last !== exp_e.last) begin
            $error("last mismatch: expected %0b, got %0b", exp_e.last, entry_bus.last);
            error_count++;
          end
        end
      end
      // back-pressure
      r = $urandom_range(0, 99);
      if (stall_left > 0) begin
        stall_left--;
        entry_bus.ready <= 1'b0;
      end else if (sink_quiet || r < 75) begin
        entry_bus.ready <= 1'b1;
      end else begin
        stall_left = (r < 96) ? $urandom_range(0, 2) : $urandom_range(8, 40);
        entry_bus.ready <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("grid_stencil_matrix_entry_generator_top regression: fail");
      $finish;
    end
  end

  function automatic void push_elem(input int y, input int x, input int f, input int d);
    elem_t e;
    e.cell_y      = COORD_W'(y);
    e.cell_x      = COORD_W'(x);
    e.field_index = FLD_W'(f);
    e.component   = COMP_W'(d);
    queued_elems = {queued_elems, e};
  endfunction

  // biased towards the edges where neighbours wrap or drop
  function automatic int pick_coord(input int n);
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 20) return n - 1;
    if (r < 25) return 1;
    if (r < 30) return n - 2;
    return $urandom_range(0, n - 1);
  endfunction

  function automatic int pick_grid_raw();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(3, 8);
    if (r < 70) return $urandom_range(9, 64);
    if (r < 80) return $urandom_range(0, 2);
    if (r < 90) return $urandom_range(250, 256);
    return $urandom_range(257, 511);
  endfunction

  // block is idle: nothing queued, nothing on the wire, nothing outstanding
  task automatic wait_idle();
    while (queued_elems.size() != 0 || elem_in_flight || awaited_entries.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one register write; valid is left high for the caller to lower
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'(value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      REG_OPERATOR_KIND: op_kind   = data[KIND_W-1:0];
      REG_GRID_SIZE:     grid_raw  = data[NSZ_W-1:0];
      REG_FIELD_COUNT:   field_raw = data[CNT_W-1:0];
      REG_VECTOR_DIMS:   dims_raw  = data[CNT_W-1:0];
      REG_BOUNDARY_MODE: wrap_raw  = data[0];
      default: ;
    endcase
  endtask

  task automatic configure(input int kind, input int grid, input int fields,
                           input int dims, input int wrap, input bit poke_unused);
    wait_idle();
    write_reg(REG_OPERATOR_KIND, kind);
    write_reg(REG_GRID_SIZE, grid);
    write_reg(REG_FIELD_COUNT, fields);
    write_reg(REG_VECTOR_DIMS, dims);
    write_reg(REG_BOUNDARY_MODE, wrap);
    if (poke_unused) write_reg(REG_UNUSED, 9'h1FF);
    cfg_bus.valid <= 1'b0;
    configs_applied++;
  endtask

  task automatic push_well_formed();
    int dlim;
    dlim = (op_kind == KIND_LAPLACE) ? dims_n() : 2;
    push_elem(pick_coord(grid_n()), pick_coord(grid_n()),
              $urandom_range(0, fields_n() - 1), $urandom_range(0, dlim - 1));
  endtask

  task automatic push_noise();
    push_elem($urandom_range(0, 255), $urandom_range(0, 255),
              $urandom_range(0, 3), $urandom_range(0, 3));
  endtask

  initial begin
    int pick, got, kind;
    bit paused;
    clk   = 1'b0;
    rst_n = 1'b0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.index        = '0;
    cfg_bus.data         = '0;
    elem_bus.valid       = 1'b0;
    elem_bus.cell_y      = '0;
    elem_bus.cell_x      = '0;
    elem_bus.field_index = '0;
    elem_bus.component   = '0;
    entry_bus.ready      = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset registers: Laplacian, 64x64, one field, two components, zero edge
    push_elem(0, 0, 0, 0);
    push_elem(0, 63, 0, 1);
    push_elem(63, 0, 0, 0);
    push_elem(63, 63, 0, 1);
    push_elem(10, 20, 0, 0);
    push_elem(64, 5, 0, 0);
    push_elem(5, 64, 0, 0);
    push_elem(255, 255, 3, 3);
    push_elem(3, 3, 1, 0);
    push_elem(3, 3, 0, 2);

    // divergence on the smallest periodic grid, sizes below and above range
    configure(KIND_DIV, 0, 7, 0, 1, 1'b0);
    push_elem(0, 0, 0, 0);
    push_elem(2, 2, 3, 1);
    push_elem(1, 1, 0, 1);
    push_elem(0, 2, 0, 2);

    // gradient on the largest periodic grid
    configure(KIND_GRAD, 511, 4, 7, 1, 1'b0);
    push_elem(0, 0, 3, 0);
    push_elem(255, 255, 3, 1);
    push_elem(255, 0, 0, 0);
    push_elem(0, 255, 2, 1);

    // unused operator code, plus a write to an empty register slot
    configure(KIND_NONE, 8, 1, 1, 0, 1'b1);
    push_elem(1, 1, 0, 0);
    push_elem(0, 0, 0, 0);

    // Laplacian at full size, every field and component, up to the largest index
    configure(KIND_LAPLACE, MAX_GRID, MAX_FIELDS, MAX_DIMS, 1, 1'b0);
    push_elem(255, 255, 3, 3);
    push_elem(0, 0, 0, 0);
    push_elem(128, 0, 1, 2);

    // random configurations with random elements
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      pick = $urandom_range(0, 9);
      kind = (pick < 4) ? KIND_LAPLACE : (pick < 7) ? KIND_DIV :
             (pick < 9) ? KIND_GRAD : KIND_NONE;
      configure(kind | ($urandom_range(0, 127) << KIND_W), pick_grid_raw(),
                $urandom_range(0, 511), $urandom_range(0, 511),
                $urandom_range(0, 511), 1'b0);
      sender_quiet = ($urandom_range(0, 3) == 0);
      sink_quiet   = ($urandom_range(0, 3) == 0);
      if (op_kind == KIND_NONE) begin
        repeat (NONE_ITEMS) push_noise();
      end else begin
        got    = 0;
        paused = 1'b0;
        while (got < PHASE_ITEMS) begin
          if ($urandom_range(0, 99) < 15) begin
            push_noise();
          end else begin
            push_well_formed();
            got++;
          end
          // hold the sender off once until everything has drained
          if (ph == 2 && !paused && got == PHASE_ITEMS / 2) begin
            wait_idle();
            paused = 1'b1;
          end
        end
      end
    end

    wait_idle();
    $display("Run: %0d elements across %0d register settings, %0d with no entries.",
             elems_sent, configs_applied + 1, silent_elems);
    $display("Run: %0d matrix entries compared, %0d errors.", entries_checked, error_count);
    if (error_count == 0) begin
      $display("grid_stencil_matrix_entry_generator_top regression: pass");
    end else begin
      $display("grid_stencil_matrix_entry_generator_top regression: fail");
    end
    $finish;
  end

endmodule
